>>> sv/pdms_pkg.sv
// shared constants, payload structs and calendar helpers for the packed date month shift
package pdms_pkg;

   localparam int DATE_W  = 27;
   localparam int DELTA_W = 18;
   localparam int OUT_W   = 25;
   localparam int STAT_W  = 2;

   localparam int DAY_SCALE   = 1000000;
   localparam int MONTH_SCALE = 10000;
   localparam int CENTURY     = 100;
   localparam int MONTHS      = 12;
   localparam int MAX_YEAR    = 9999;

   // floor(2^s / divisor): the quotient comes out exact or one low, fixed by one compare
   localparam int DAY_RECIP       = (1 << 27) / DAY_SCALE;
   localparam int MONTH_RECIP     = (1 << 20) / MONTH_SCALE;
   localparam int YEAR_CENT_RECIP = (1 << 14) / CENTURY;
   localparam int MONTH12_RECIP   = (1 << 18) / MONTHS;
   localparam int NEXT_CENT_RECIP = (1 << 15) / CENTURY;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BAD_DATE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_YEAR = 2'd2;

   // unpacked input date and month offset
   typedef struct packed {
      logic [7:0]         day;
      logic [6:0]         month;
      logic [13:0]        year;
      logic [DELTA_W-1:0] delta;
   } ymd_type;

   // target date before the day clamp
   typedef struct packed {
      logic [4:0]        day;
      logic [3:0]        month;
      logic [14:0]       year;
      logic [STAT_W-1:0] status;
   } shift_type;

   function automatic logic leap_year(input logic [1:0] year_lo, input logic [6:0] year_rem,
                                      input logic [1:0] cent_lo);
      return (year_lo == 2'd0) && ((year_rem != 7'd0) || (cent_lo == 2'd0));
   endfunction

   // zero for a month outside 1..12
   function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
      logic [4:0] days;
      days = 5'd0;
      unique case (month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                    days = 5'd30;
         7'd2:                                       days = leap ? 5'd29 : 5'd28;
         default:                                    days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

>>> sv/pdms_split.sv
// four-stage split of the packed date into day, month and year by constant reciprocals
module pdms_split (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [pdms_pkg::DATE_W-1:0]  in_date,
   input  logic [pdms_pkg::DELTA_W-1:0] in_delta,
   output logic                         out_valid,
   input  logic                         out_ready,
   output pdms_pkg::ymd_type            out_data
);
   import pdms_pkg::*;

   // stage a: approximate day quotient
   logic               a_valid_ff;
   logic [DATE_W-1:0]  a_date_ff;
   logic [DELTA_W-1:0] a_delta_ff;
   logic [7:0]         a_quot_ff;
   logic [7:0]         a_quot_in;
   logic [34:0]        a_prod;
   logic               a_ready;

   // stage b: corrected day and remainder
   logic               b_valid_ff;
   logic [7:0]         b_day_ff;
   logic [19:0]        b_rest_ff;
   logic [DELTA_W-1:0] b_delta_ff;
   logic [7:0]         b_day_in;
   logic [19:0]        b_rest_in;
   logic [DATE_W-1:0]  b_sub;
   logic [DATE_W-1:0]  b_rem;
   logic               b_ready;

   // stage c: approximate month quotient
   logic               c_valid_ff;
   logic [7:0]         c_day_ff;
   logic [19:0]        c_rest_ff;
   logic [DELTA_W-1:0] c_delta_ff;
   logic [6:0]         c_quot_ff;
   logic [6:0]         c_quot_in;
   logic [26:0]        c_prod;
   logic               c_ready;

   // stage d: corrected month and year
   logic               d_valid_ff;
   ymd_type            d_data_ff;
   ymd_type            d_data_in;
   logic [19:0]        d_sub;
   logic [19:0]        d_rem;
   logic               d_ready;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_prod    = 35'(in_date) * 35'(DAY_RECIP);
   assign a_quot_in = a_prod[34:27];

   always_comb begin
      b_sub = 27'(a_quot_ff) * 27'(DAY_SCALE);
      b_rem = a_date_ff - b_sub;
      if (b_rem >= 27'(DAY_SCALE)) begin
         b_day_in  = a_quot_ff + 8'd1;
         b_rest_in = 20'(b_rem - 27'(DAY_SCALE));
      end else begin
         b_day_in  = a_quot_ff;
         b_rest_in = 20'(b_rem);
      end
   end

   assign c_prod    = 27'(b_rest_ff) * 27'(MONTH_RECIP);
   assign c_quot_in = c_prod[26:20];

   always_comb begin
      d_sub           = 20'(c_quot_ff) * 20'(MONTH_SCALE);
      d_rem           = c_rest_ff - d_sub;
      d_data_in.day   = c_day_ff;
      d_data_in.delta = c_delta_ff;
      if (d_rem >= 20'(MONTH_SCALE)) begin
         d_data_in.month = c_quot_ff + 7'd1;
         d_data_in.year  = 14'(d_rem - 20'(MONTH_SCALE));
      end else begin
         d_data_in.month = c_quot_ff;
         d_data_in.year  = 14'(d_rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_date_ff  <= in_date;
         a_delta_ff <= in_delta;
         a_quot_ff  <= a_quot_in;
      end
      if (b_ready) begin
         b_day_ff   <= b_day_in;
         b_rest_ff  <= b_rest_in;
         b_delta_ff <= a_delta_ff;
      end
      if (c_ready) begin
         c_day_ff   <= b_day_ff;
         c_rest_ff  <= b_rest_ff;
         c_delta_ff <= b_delta_ff;
         c_quot_ff  <= c_quot_in;
      end
      if (d_ready) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

>>> sv/pdms_shift.sv
// three-stage date check and month arithmetic giving the target year and month
module pdms_shift (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pdms_pkg::ymd_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output pdms_pkg::shift_type out_data
);
   import pdms_pkg::*;

   // stage e: month count and century estimate
   logic               e_valid_ff;
   logic [7:0]         e_day_ff;
   logic [6:0]         e_month_ff;
   logic [13:0]        e_year_ff;
   logic signed [19:0] e_total_ff;
   logic [7:0]         e_cent_ff;
   logic [17:0]        e_base;
   logic signed [19:0] e_total_in;
   logic [21:0]        e_cprod;
   logic [7:0]         e_cent_in;
   logic               e_ready;

   // stage f: validity and year estimate
   logic               f_valid_ff;
   logic               f_bad_ff;
   logic               f_neg_ff;
   logic [17:0]        f_tot_ff;
   logic [14:0]        f_quot_ff;
   logic [4:0]         f_day_ff;
   logic [13:0]        f_crem;
   logic [7:0]         f_cent;
   logic [13:0]        f_yrem;
   logic               f_leap;
   logic [4:0]         f_dim;
   logic               f_bad_in;
   logic [32:0]        f_qprod;
   logic [14:0]        f_quot_in;
   logic               f_ready;

   // stage g: corrected year and month
   logic               g_valid_ff;
   shift_type          g_data_ff;
   shift_type          g_data_in;
   logic [17:0]        g_sub;
   logic [17:0]        g_rem;
   logic [17:0]        g_month0;
   logic               g_over;
   logic               g_ready;

   assign g_ready  = !g_valid_ff || out_ready;
   assign f_ready  = !f_valid_ff || g_ready;
   assign e_ready  = !e_valid_ff || f_ready;
   assign in_ready = e_ready;

   // months since year zero, month counted from zero
   always_comb begin
      e_base     = 18'(in_data.year) * 18'(MONTHS) + 18'(in_data.month);
      e_total_in = $signed({2'b00, e_base})
                 + $signed({{2{in_data.delta[DELTA_W-1]}}, in_data.delta}) - 20'sd1;
      e_cprod    = 22'(in_data.year) * 22'(YEAR_CENT_RECIP);
      e_cent_in  = e_cprod[21:14];
   end

   always_comb begin
      f_crem = e_year_ff - 14'(e_cent_ff) * 14'(CENTURY);
      if (f_crem >= 14'(CENTURY)) begin
         f_cent = e_cent_ff + 8'd1;
         f_yrem = f_crem - 14'(CENTURY);
      end else begin
         f_cent = e_cent_ff;
         f_yrem = f_crem;
      end
      f_leap    = leap_year(e_year_ff[1:0], f_yrem[6:0], f_cent[1:0]);
      f_dim     = month_days(e_month_ff, f_leap);
      f_bad_in  = (f_dim == 5'd0) || (e_day_ff == 8'd0) || (e_day_ff > {3'b000, f_dim});
      f_qprod   = 33'(e_total_ff[17:0]) * 33'(MONTH12_RECIP);
      f_quot_in = f_qprod[32:18];
   end

   always_comb begin
      g_sub = 18'(f_quot_ff) * 18'(MONTHS);
      g_rem = f_tot_ff - g_sub;
      if (g_rem >= 18'(MONTHS)) begin
         g_data_in.year = f_quot_ff + 15'd1;
         g_month0       = g_rem - 18'(MONTHS);
      end else begin
         g_data_in.year = f_quot_ff;
         g_month0       = g_rem;
      end
      g_over          = g_data_in.year > 15'(MAX_YEAR);
      g_data_in.month = g_month0[3:0] + 4'd1;
      g_data_in.day   = f_day_ff;
      if (f_bad_ff) begin
         g_data_in.status = STATUS_BAD_DATE;
      end else if (f_neg_ff || g_over) begin
         g_data_in.status = STATUS_BAD_YEAR;
      end else begin
         g_data_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         if (e_ready) e_valid_ff <= in_valid;
         if (f_ready) f_valid_ff <= e_valid_ff;
         if (g_ready) g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready) begin
         e_day_ff   <= in_data.day;
         e_month_ff <= in_data.month;
         e_year_ff  <= in_data.year;
         e_total_ff <= e_total_in;
         e_cent_ff  <= e_cent_in;
      end
      if (f_ready) begin
         f_bad_ff  <= f_bad_in;
         f_neg_ff  <= e_total_ff[19];
         f_tot_ff  <= e_total_ff[17:0];
         f_quot_ff <= f_quot_in;
         f_day_ff  <= e_day_ff[4:0];
      end
      if (g_ready) begin
         g_data_ff <= g_data_in;
      end
   end

   assign out_valid = g_valid_ff;
   assign out_data  = g_data_ff;

endmodule

>>> sv/pdms_pack.sv
// three-stage day clamp to the target month and repack into DDMMYYYY
module pdms_pack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  pdms_pkg::shift_type         in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [pdms_pkg::OUT_W-1:0]  out_date,
   output logic [pdms_pkg::STAT_W-1:0] out_status
);
   import pdms_pkg::*;

   // stage h: century estimate of the target year
   logic              h_valid_ff;
   shift_type         h_data_ff;
   logic [8:0]        h_cent_ff;
   logic [23:0]       h_prod;
   logic [8:0]        h_cent_in;
   logic              h_ready;

   // stage i: leap rule and day clamp
   logic              i_valid_ff;
   logic [4:0]        i_day_ff;
   logic [3:0]        i_month_ff;
   logic [14:0]       i_year_ff;
   logic [STAT_W-1:0] i_status_ff;
   logic [14:0]       i_crem;
   logic [8:0]        i_cent;
   logic [14:0]       i_yrem;
   logic              i_leap;
   logic [4:0]        i_dim;
   logic [4:0]        i_day_in;
   logic              i_ready;

   // stage j: repack
   logic              j_valid_ff;
   logic [OUT_W-1:0]  j_date_ff;
   logic [STAT_W-1:0] j_status_ff;
   logic [OUT_W-1:0]  j_date_in;
   logic              j_ready;

   assign j_ready  = !j_valid_ff || out_ready;
   assign i_ready  = !i_valid_ff || j_ready;
   assign h_ready  = !h_valid_ff || i_ready;
   assign in_ready = h_ready;

   assign h_prod    = 24'(in_data.year) * 24'(NEXT_CENT_RECIP);
   assign h_cent_in = h_prod[23:15];

   always_comb begin
      i_crem = h_data_ff.year - 15'(h_cent_ff) * 15'(CENTURY);
      if (i_crem >= 15'(CENTURY)) begin
         i_cent = h_cent_ff + 9'd1;
         i_yrem = i_crem - 15'(CENTURY);
      end else begin
         i_cent = h_cent_ff;
         i_yrem = i_crem;
      end
      i_leap   = leap_year(h_data_ff.year[1:0], i_yrem[6:0], i_cent[1:0]);
      i_dim    = month_days(7'(h_data_ff.month), i_leap);
      i_day_in = (h_data_ff.day > i_dim) ? i_dim : h_data_ff.day;
   end

   always_comb begin
      if (i_status_ff == STATUS_OK) begin
         j_date_in = 25'(i_day_ff) * 25'(DAY_SCALE) + 25'(i_month_ff) * 25'(MONTH_SCALE)
                   + 25'(i_year_ff);
      end else begin
         j_date_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
      end else begin
         if (h_ready) h_valid_ff <= in_valid;
         if (i_ready) i_valid_ff <= h_valid_ff;
         if (j_ready) j_valid_ff <= i_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (h_ready) begin
         h_data_ff <= in_data;
         h_cent_ff <= h_cent_in;
      end
      if (i_ready) begin
         i_day_ff    <= i_day_in;
         i_month_ff  <= h_data_ff.month;
         i_year_ff   <= h_data_ff.year;
         i_status_ff <= h_data_ff.status;
      end
      if (j_ready) begin
         j_date_ff   <= j_date_in;
         j_status_ff <= i_status_ff;
      end
   end

   assign out_valid  = j_valid_ff;
   assign out_date   = j_date_ff;
   assign out_status = j_status_ff;

endmodule

>>> sv/packed_date_month_shift_top.sv
// Packed date month shift: moves a DDMMYYYY date by a signed number of months.
// Request channel (req_valid/req_ready) carries req_packed_date and the signed
// req_month_delta; response channel (rsp_valid/rsp_ready) returns rsp_shifted_date
// and rsp_status (ok, input date invalid, target year outside 0..9999).
// One response for every request, in order; shifted_date is zero unless status is ok.
// The datapath is a ten-stage pipeline: split by reciprocal multiplies (four stages),
// date check and month arithmetic (three), leap rule, day clamp and repack (three).
// One request is taken every cycle while the response side keeps up.
// Each stage holds its item until the next stage frees, so a stalled rsp_ready backs
// up stage by stage: empty stages still fill and req_ready drops only once the
// pipeline is full. Nothing is dropped or repeated under a stall.
// Synchronous reset clears all stage valid bits; req_ready is high the cycle after.
module packed_date_month_shift_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pdms_pkg::DATE_W-1:0]  req_packed_date,
   input  logic [pdms_pkg::DELTA_W-1:0] req_month_delta,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pdms_pkg::OUT_W-1:0]   rsp_shifted_date,
   output logic [pdms_pkg::STAT_W-1:0]  rsp_status
);
   import pdms_pkg::*;

   logic      split_valid;
   logic      split_ready;
   ymd_type   split_data;
   logic      shift_valid;
   logic      shift_ready;
   shift_type shift_data;

   pdms_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_date   (req_packed_date),
      .in_delta  (req_month_delta),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   pdms_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (shift_valid),
      .out_ready (shift_ready),
      .out_data  (shift_data)
   );

   pdms_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (shift_valid),
      .in_ready   (shift_ready),
      .in_data    (shift_data),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_date   (rsp_shifted_date),
      .out_status (rsp_status)
   );

`ifndef SYNTHESIS
   // a failed result never carries a date
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_shifted_date == '0))
      else $error("nonzero date on a failed result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_BAD_DATE)
                    || (rsp_status == STATUS_BAD_YEAR))
      else $error("undefined status code");

   // an accepted target must have a real month, a nonzero day and a year up to 9999
   assert property (@(posedge clock) disable iff (reset)
      shift_valid && (shift_data.status == STATUS_OK) |->
         (shift_data.month >= 4'd1) && (shift_data.month <= 4'd12)
         && (shift_data.day != 5'd0) && (shift_data.year <= 15'(MAX_YEAR)))
      else $error("target date out of range on an ok item");

   // the pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");
`endif

endmodule
